// File: rtl/block_bitmap_allocator_top_assert.svh
// Assertion helpers for the block bitmap allocator.
`ifndef BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH
`define BLOCK_BITMAP_ALLOCATOR_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BBA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define BBA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/bba_pkg.sv
package bba_pkg;

    localparam int WORD_W            = 32;
    localparam int OFF_W             = $clog2(WORD_W);
    localparam int BLOCK_W           = 10;
    localparam int COUNT_W           = 11;
    localparam int MODE_W            = 2;
    localparam int STATUS_W          = 2;
    localparam int DEF_MAX_BLOCKS    = 1024;
    localparam int RESET_BLOCK_COUNT = 1024;

    localparam logic [COUNT_W-1:0] FREE_MAX = '1;

    localparam logic [MODE_W-1:0] MODE_CHECK = 2'd0;
    localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd1;
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd2;
    localparam logic [MODE_W-1:0] MODE_FIND  = 2'd3;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_STATE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_LOOKUP = 4'b0100,
        ST_SCAN   = 4'b1000
    } state_t;

    // Masking controls for the free-bit scanner.
    typedef struct packed {
        logic             first_word;
        logic             last_word;
        logic [OFF_W-1:0] start_off;
        logic [OFF_W-1:0] last_off;
    } scan_ctl_t;

endpackage

// File: rtl/bba_map_ram.sv
module bba_map_ram
    import bba_pkg::*;
#(
    parameter int DEPTH  = DEF_MAX_BLOCKS / WORD_W,
    parameter int ADDR_W = $clog2(DEF_MAX_BLOCKS / WORD_W)
)
(
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WORD_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WORD_W-1:0] rdata
);

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/bba_scan.sv
module bba_scan
    import bba_pkg::*;
(
    input  logic [WORD_W-1:0] data,
    input  scan_ctl_t         ctl,
    output logic              hit,
    output logic [OFF_W-1:0]  hit_off
);

    logic [WORD_W-1:0] cand;

    // Lowest clear bit of this word, at or above start_off in the first word and at or below last_off in the last word.
    always_comb
    begin
        cand    = '0;
        hit     = 1'b0;
        hit_off = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            cand[i] = ~data[i]
                    & (~ctl.first_word | (OFF_W'(i) >= ctl.start_off))
                    & (~ctl.last_word  | (OFF_W'(i) <= ctl.last_off));
        end
        for (int i = WORD_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                hit     = 1'b1;
                hit_off = OFF_W'(i);
            end
        end
    end

endmodule

// File: rtl/block_bitmap_allocator_top.sv
// An out-of-range request is answered in the cycle after it is accepted; check, free
// and allocate without search reply from ST_LOOKUP; find-free and allocate of the tracked first
// free block go on to ST_SCAN, one 32-bit map word at a time, up to MAX_BLOCKS/32 words.
// Throughput: one request at a time; the single map RAM read port and scanner set the rate.
// Reset: a clearing pass writes zero to every map word, MAX_BLOCKS/32 words (32 by default),
// with in_ready low; configuration writes are taken throughout.
`include "block_bitmap_allocator_top_assert.svh"

module block_bitmap_allocator_top
    import bba_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [COUNT_W-1:0]  cfg_wdata,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [MODE_W-1:0]   mode,
    input  logic [BLOCK_W-1:0]  block,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] status,
    output logic [BLOCK_W-1:0]  found_block,
    output logic [BLOCK_W-1:0]  first_free,
    output logic                first_free_valid,
    output logic [COUNT_W-1:0]  free_count
);

    localparam int WORDS     = (MAX_BLOCKS + WORD_W - 1) / WORD_W;
    localparam int ADDR_W    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int EFF_W     = $clog2(MAX_BLOCKS + 1);
    localparam int POS_W     = (EFF_W > COUNT_W) ? EFF_W : COUNT_W;
    localparam int RESET_EFF = (MAX_BLOCKS < RESET_BLOCK_COUNT) ? MAX_BLOCKS
                                                                : RESET_BLOCK_COUNT;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(WORDS - 1);
    localparam logic [POS_W-1:0]  MAX_POS   = POS_W'(MAX_BLOCKS);
    localparam logic [POS_W-1:0]  RST_EFF   = POS_W'(RESET_EFF);

    state_t              state_reg, state_next;
    logic [ADDR_W-1:0]   clr_addr_reg, clr_addr_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [POS_W-1:0]    blk_reg, blk_next;
    logic [POS_W-1:0]    start_pos_reg, start_pos_next;
    logic [ADDR_W-1:0]   scan_word_reg, scan_word_next;
    logic [POS_W-1:0]    eff_reg, eff_next;
    logic [POS_W-1:0]    last_pos_reg, last_pos_next;
    logic [POS_W-1:0]    ptr_reg, ptr_next;
    logic                known_reg, known_next;
    logic [COUNT_W-1:0]  free_total_reg, free_total_next;
    logic                out_valid_reg, out_valid_next;
    status_t             status_reg, status_next;
    logic [BLOCK_W-1:0]  found_reg, found_next;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    scan_ctl_t           scan_ctl;
    logic                scan_hit;
    logic [OFF_W-1:0]    scan_off;
    logic [POS_W-1:0]    scan_pos;

    logic [POS_W-1:0]    in_blk;
    logic [POS_W-1:0]    cfg_ext;
    logic                accept;
    logic                bit_used;
    logic [WORD_W-1:0]   bit_mask;
    logic [ADDR_W-1:0]   last_word;

    assign in_blk    = POS_W'(block);
    assign cfg_ext   = POS_W'(cfg_wdata);
    assign in_ready  = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept    = in_valid && in_ready;
    assign bit_used  = ram_rdata[blk_reg[OFF_W-1:0]];
    assign bit_mask  = WORD_W'(1) << blk_reg[OFF_W-1:0];
    assign last_word = last_pos_reg[OFF_W +: ADDR_W];

    assign scan_ctl.first_word = (scan_word_reg == start_pos_reg[OFF_W +: ADDR_W]);
    assign scan_ctl.last_word  = (scan_word_reg == last_word);
    assign scan_ctl.start_off  = start_pos_reg[OFF_W-1:0];
    assign scan_ctl.last_off   = last_pos_reg[OFF_W-1:0];
    assign scan_pos            = POS_W'({scan_word_reg, scan_off});

    bba_map_ram #(
        .DEPTH  (WORDS),
        .ADDR_W (ADDR_W)
    ) u_map_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    bba_scan u_scan (
        .data    (ram_rdata),
        .ctl     (scan_ctl),
        .hit     (scan_hit),
        .hit_off (scan_off)
    );

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        mode_next       = mode_reg;
        blk_next        = blk_reg;
        start_pos_next  = start_pos_reg;
        scan_word_next  = scan_word_reg;
        eff_next        = eff_reg;
        last_pos_next   = last_pos_reg;
        ptr_next        = ptr_reg;
        known_next      = known_reg;
        free_total_next = free_total_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        found_next      = found_reg;
        ram_we          = 1'b0;
        ram_waddr       = blk_reg[OFF_W +: ADDR_W];
        ram_wdata       = ram_rdata;
        ram_raddr       = in_blk[OFF_W +: ADDR_W];

        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_addr_reg;
                ram_wdata = '0;
                if (clr_addr_reg == LAST_ADDR)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    clr_addr_next = clr_addr_reg + 1'b1;
                end
            end

            ST_IDLE:
            begin
                // Read the addressed word while the request transfers.
                if (accept)
                begin
                    mode_next = mode;
                    blk_next  = in_blk;
                    if (in_blk >= eff_reg)
                    begin
                        status_next    = STATUS_RANGE;
                        found_next     = '0;
                        out_valid_next = 1'b1;
                    end
                    else
                    begin
                        state_next = ST_LOOKUP;
                    end
                end
            end

            ST_LOOKUP:
            begin
                found_next  = '0;
                status_next = STATUS_OK;
                state_next  = ST_IDLE;
                unique case (mode_reg)
                    MODE_CHECK:
                    begin
                        status_next    = bit_used ? STATUS_OK : STATUS_STATE;
                        out_valid_next = 1'b1;
                    end
                    MODE_ALLOC:
                    begin
                        if (bit_used)
                        begin
                            status_next    = STATUS_STATE;
                            out_valid_next = 1'b1;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata | bit_mask;
                            if (free_total_reg != '0)
                            begin
                                free_total_next = free_total_reg - 1'b1;
                            end
                            start_pos_next = blk_reg + 1'b1;
                            scan_word_next = start_pos_next[OFF_W +: ADDR_W];
                            ram_raddr      = start_pos_next[OFF_W +: ADDR_W];
                            if (!(known_reg && (blk_reg == ptr_reg)))
                            begin
                                out_valid_next = 1'b1;
                            end
                            else if (start_pos_next >= eff_reg)
                            begin
                                // Nothing above: pointer goes unknown.
                                ptr_next       = '0;
                                known_next     = 1'b0;
                                out_valid_next = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_SCAN;
                            end
                        end
                    end
                    MODE_FREE:
                    begin
                        if (!bit_used)
                        begin
                            status_next = STATUS_STATE;
                        end
                        else
                        begin
                            ram_we    = 1'b1;
                            ram_wdata = ram_rdata & ~bit_mask;
                            if (!known_reg || (blk_reg < ptr_reg))
                            begin
                                ptr_next   = blk_reg;
                                known_next = 1'b1;
                            end
                            if (free_total_reg != FREE_MAX)
                            begin
                                free_total_next = free_total_reg + 1'b1;
                            end
                        end
                        out_valid_next = 1'b1;
                    end
                    MODE_FIND:
                    begin
                        start_pos_next = blk_reg;
                        scan_word_next = blk_reg[OFF_W +: ADDR_W];
                        ram_raddr      = blk_reg[OFF_W +: ADDR_W];
                        state_next     = ST_SCAN;
                    end
                    default:
                    begin
                        out_valid_next = 1'b1;
                    end
                endcase
            end

            ST_SCAN:
            begin
                // Evaluate the current word, prefetch the next one.
                ram_raddr      = scan_word_reg + 1'b1;
                scan_word_next = scan_word_reg + 1'b1;
                if (scan_hit || scan_ctl.last_word)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                    found_next     = '0;
                    status_next    = STATUS_OK;
                    scan_word_next = scan_word_reg;
                    if (mode_reg == MODE_ALLOC)
                    begin
                        ptr_next   = scan_hit ? scan_pos : '0;
                        known_next = scan_hit;
                    end
                    else if (scan_hit)
                    begin
                        found_next = scan_pos[BLOCK_W-1:0];
                    end
                    else
                    begin
                        status_next = STATUS_STATE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Reload the effective count and free total on a register write.
        if (cfg_we)
        begin
            eff_next        = (cfg_ext > MAX_POS) ? MAX_POS : cfg_ext;
            last_pos_next   = eff_next - 1'b1;
            free_total_next = eff_next[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_addr_reg   <= '0;
            eff_reg        <= RST_EFF;
            last_pos_reg   <= RST_EFF - 1'b1;
            ptr_reg        <= '0;
            known_reg      <= 1'b1;
            free_total_reg <= RST_EFF[COUNT_W-1:0];
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_addr_reg   <= clr_addr_next;
            eff_reg        <= eff_next;
            last_pos_reg   <= last_pos_next;
            ptr_reg        <= ptr_next;
            known_reg      <= known_next;
            free_total_reg <= free_total_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg      <= mode_next;
        blk_reg       <= blk_next;
        start_pos_reg <= start_pos_next;
        scan_word_reg <= scan_word_next;
        status_reg    <= status_next;
        found_reg     <= found_next;
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign found_block      = found_reg;
    assign first_free       = ptr_reg[BLOCK_W-1:0];
    assign first_free_valid = known_reg;
    assign free_count       = free_total_reg;

    `BBA_ASSERT_NEXT(a_range_reply, accept && (in_blk >= eff_reg),
        out_valid && (status == STATUS_RANGE), "out-of-range request not answered next cycle")
    `BBA_ASSERT_NOW(a_scan_bound, state_reg == ST_SCAN,
        scan_word_reg <= last_word, "scan ran past the last map word")
    `BBA_ASSERT_NOW(a_slot_free, (state_reg == ST_LOOKUP) || (state_reg == ST_SCAN),
        !out_valid_reg, "result slot occupied while a request is in progress")

endmodule
